@@ hw/rtl/mrtt_pkg.sv @@
// Package for the multi-slot repeat timer table: operation, status and sequencer state
// codes and the request, response and slot-record types. No dependencies.
`timescale 1ns / 1ps
package mrtt_pkg;

   typedef enum logic [2:0] {
      KIND_REGISTER   = 3'd0,
      KIND_UNREGISTER = 3'd1,
      KIND_CLEAR_ALL  = 3'd2,
      KIND_TICK       = 3'd3,
      KIND_START      = 3'd4,
      KIND_STOP       = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ST_ACCEPTED = 3'd0,
      ST_REJECTED = 3'd1,
      ST_DONE     = 3'd2,
      ST_FIRED    = 3'd3,
      ST_NONE     = 3'd4,
      ST_IGNORED  = 3'd5,
      ST_AUTOSTOP = 3'd6
   } status_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic [7:0]         callback_tag;
      logic [31:0]        period_ticks;
      logic signed [31:0] repeat_count;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [3:0] slot;
      logic [7:0] fired_tag;
      logic       last;
   } rsp_type;

   // One slot record as it circulates around the ring of cells.
   typedef struct packed {
      logic [15:0]        tag;
      logic [31:0]        period;
      logic signed [31:0] repeats;
      logic [31:0]        ticks;
   } slot_rec_type;

   typedef enum logic [1:0] {
      FSM_IDLE = 2'd0,
      FSM_WALK = 2'd1,
      FSM_EMIT = 2'd2
   } fsm_type;

endpackage

@@ hw/rtl/mrtt_cell.sv @@
// One slot cell of the timer ring: holds a slot record and hands it to the
// next cell each shift cycle. Depends on mrtt_pkg.
`timescale 1ns / 1ps
module mrtt_cell
   import mrtt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         shift,
   input  logic         clear,
   input  slot_rec_type rec_in,
   output slot_rec_type rec_out
);

   slot_rec_type rec_ff;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         rec_ff.tag   <= '0;
         rec_ff.ticks <= '0;
      end else if (shift) begin
         rec_ff.tag   <= rec_in.tag;
         rec_ff.ticks <= rec_in.ticks;
      end
      if (clear) begin
         rec_ff.period  <= '0;
         rec_ff.repeats <= '0;
      end else if (shift) begin
         rec_ff.period  <= rec_in.period;
         rec_ff.repeats <= rec_in.repeats;
      end
   end

   assign rec_out = rec_ff;

endmodule

@@ hw/rtl/multi_slot_repeat_timer_table_unit.sv @@
// Top level of the multi-slot repeat timer table: ring of slot cells, one
// head processing stage and the control sequencer. Depends on mrtt_pkg, mrtt_cell.
//
//   channel | dir | ports
//   req     | in  | req_valid, req_stall, req_data (req_type)
//   rsp     | out | rsp_valid, rsp_stall, rsp_data (rsp_type)
//
// Start, stop, clear-all and requests answered up front finish from the idle state.
// Register, unregister and running ticks walk the ring: the accept, one shift per
// slot as the ring rotates, and the EMIT state to post the final result.
// Each fired result is held one step so the next firing or the walk end sets last;
// a firing slot stalls the walk while the output register is still full.
// Synchronous reset clears all tags, counters, the running flag and control.
`timescale 1ns / 1ps
module multi_slot_repeat_timer_table_unit
   import mrtt_pkg::*;
#(
   parameter int SLOTS    = 10,
   parameter int TAG_BITS = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam logic [7:0] TAG_MASK = 8'((64'd1 << TAG_BITS) - 64'd1);

   fsm_type       state_ff, state_in;
   req_type       req_ff, req_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [CW-1:0] active_ff, active_in;
   logic          running_ff, running_in;
   logic          done_ff, done_in;      // register/unregister matched
   logic          clear_all;
   rsp_type       out_ff, out_in;
   logic          out_valid_ff, out_valid_in;
   rsp_type       held_ff, held_in;
   logic          held_valid_ff, held_valid_in;
   logic          shift;
   slot_rec_type  ring [SLOTS];
   slot_rec_type  head, head_new;
   logic [7:0]    tag_in;
   logic          fire;
   logic          out_free;

   assign tag_in = req_ff.callback_tag & TAG_MASK;

   genvar g;
   generate
      for (g = 0; g < SLOTS; g++) begin : g_cell
         slot_rec_type nxt;
         if (g == SLOTS - 1) begin : g_last
            assign nxt = head_new;
         end else begin : g_mid
            assign nxt = ring[g+1];
         end
         mrtt_cell u_cell (
            .clock  (clock),
            .reset  (reset),
            .shift  (shift),
            .clear  (clear_all),
            .rec_in (nxt),
            .rec_out(ring[g])
         );
      end
   endgenerate

   assign head = ring[0];

   // Head processing for the slot currently at cell 0.
   always_comb begin
      head_new = head;
      fire     = 1'b0;
      unique case (req_ff.kind)
         KIND_REGISTER: begin
            if (!done_ff && head.tag == '0) begin
               head_new.tag     = 16'(tag_in);
               head_new.period  = req_ff.period_ticks;
               head_new.repeats = req_ff.repeat_count;
               head_new.ticks   = '0;
            end
         end
         KIND_UNREGISTER: begin
            if (!done_ff && tag_in != '0 && head.tag == 16'(tag_in))
               head_new.tag = '0;
         end
         KIND_TICK: begin
            if (head.tag != '0) begin
               head_new.ticks = head.ticks + 32'd1;
               if (head_new.ticks == head.period) begin
                  head_new.ticks = '0;
                  if (head.repeats == '0) begin
                     head_new.tag = '0;
                  end else begin
                     fire = 1'b1;
                     if (!head.repeats[31]) begin
                        head_new.repeats = head.repeats - 32'sd1;
                        if (head_new.repeats == '0) head_new.tag = '0;
                     end
                  end
               end
            end
         end
         default: ;
      endcase
   end

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != FSM_IDLE) || !out_free;

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      idx_in        = idx_ff;
      active_in     = active_ff;
      running_in    = running_ff;
      done_in       = done_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      shift         = 1'b0;
      clear_all     = 1'b0;
      unique case (state_ff)
         FSM_IDLE: begin
            if (req_valid && !req_stall) begin
               req_in        = req_data;
               done_in       = 1'b0;
               held_valid_in = 1'b0;
               idx_in        = '0;
               out_in        = '{status: ST_DONE, slot: '0, fired_tag: '0, last: 1'b1};
               unique case (req_data.kind)
                  KIND_REGISTER: begin
                     if ((req_data.callback_tag & TAG_MASK) == '0 ||
                         req_data.period_ticks == '0 || req_data.repeat_count == '0 ||
                         32'(active_ff) >= 32'(SLOTS)) begin
                        out_in.status = ST_REJECTED;
                        out_valid_in  = 1'b1;
                     end else begin
                        state_in = FSM_WALK;
                     end
                  end
                  KIND_UNREGISTER: begin
                     if (active_ff == '0 || (req_data.callback_tag & TAG_MASK) == '0)
                        out_valid_in = 1'b1;
                     else
                        state_in = FSM_WALK;
                  end
                  KIND_CLEAR_ALL: begin
                     clear_all    = 1'b1;
                     active_in    = '0;
                     running_in   = 1'b0;
                     out_valid_in = 1'b1;
                  end
                  KIND_TICK: begin
                     if (!running_ff) begin
                        out_in.status = ST_IGNORED;
                        out_valid_in  = 1'b1;
                     end else if (active_ff == '0) begin
                        clear_all     = 1'b1;
                        running_in    = 1'b0;
                        out_in.status = ST_AUTOSTOP;
                        out_valid_in  = 1'b1;
                     end else begin
                        state_in = FSM_WALK;
                     end
                  end
                  KIND_START: begin
                     running_in   = 1'b1;
                     out_valid_in = 1'b1;
                  end
                  KIND_STOP: begin
                     running_in   = 1'b0;
                     out_valid_in = 1'b1;
                  end
                  default: begin
                     out_in.status = ST_REJECTED;
                     out_valid_in  = 1'b1;
                  end
               endcase
            end
         end
         FSM_WALK: begin
            // Hold a firing slot while the previous result cannot leave.
            if (!(fire && held_valid_ff && !out_free)) begin
               shift = 1'b1;
               if (head.tag != '0 && head_new.tag == '0) active_in = active_ff - CW'(1);
               if (head.tag == '0 && head_new.tag != '0) begin
                  active_in     = active_ff + CW'(1);
                  held_in       = '{status: ST_ACCEPTED, slot: 4'(idx_ff), fired_tag: '0,
                                    last: 1'b1};
                  held_valid_in = 1'b1;
               end
               if (req_ff.kind != KIND_TICK && head_new.tag != head.tag) done_in = 1'b1;
               if (fire) begin
                  if (held_valid_ff) begin
                     out_in       = held_ff;
                     out_valid_in = 1'b1;
                  end
                  held_in       = '{status: ST_FIRED, slot: 4'(idx_ff),
                                    fired_tag: 8'(head.tag), last: 1'b0};
                  held_valid_in = 1'b1;
               end
               if (32'(idx_ff) == 32'(SLOTS - 1)) begin
                  idx_in   = '0;
                  state_in = FSM_EMIT;
               end else begin
                  idx_in = idx_ff + IW'(1);
               end
            end
         end
         FSM_EMIT: begin
            if (out_free) begin
               state_in      = FSM_IDLE;
               out_valid_in  = 1'b1;
               held_valid_in = 1'b0;
               if (held_valid_ff) begin
                  out_in      = held_ff;
                  out_in.last = 1'b1;
               end else if (req_ff.kind == KIND_TICK) begin
                  out_in = '{status: ST_NONE, slot: '0, fired_tag: '0, last: 1'b1};
               end else if (req_ff.kind == KIND_REGISTER) begin
                  out_in = '{status: ST_REJECTED, slot: '0, fired_tag: '0, last: 1'b1};
               end else begin
                  out_in = '{status: ST_DONE, slot: '0, fired_tag: '0, last: 1'b1};
               end
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= FSM_IDLE;
         req_ff        <= '0;
         idx_ff        <= '0;
         active_ff     <= '0;
         running_ff    <= 1'b0;
         done_ff       <= 1'b0;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         out_ff        <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         req_ff        <= req_in;
         idx_ff        <= idx_in;
         active_ff     <= active_in;
         running_ff    <= running_in;
         done_ff       <= done_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         out_ff        <= out_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(active_ff) <= 32'(SLOTS))
      else $error("active count above slot total");
   a_idle_walk: assert property (@(posedge clock) disable iff (reset)
      state_ff == FSM_IDLE |-> !shift)
      else $error("ring shifted while idle");
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != FSM_IDLE |-> req_stall)
      else $error("request taken mid walk");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");
`endif

endmodule

@@ tb/tb_multi_slot_repeat_timer_table_unit.sv @@
// Self-checking testbench for multi_slot_repeat_timer_table_unit: a directed table and random
// register/unregister/clear/tick/start/stop and invalid-kind traffic, checked against an
// in-bench timer-table predictor. Depends on mrtt_pkg and the RTL of the block.
`timescale 1ns / 1ps
module tb_multi_slot_repeat_timer_table_unit;
   import mrtt_pkg::*;

   localparam int SLOTS = 10;
   localparam int WATCHDOG_CYCLES = 20000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   multi_slot_repeat_timer_table_unit #(.SLOTS(SLOTS), .TAG_BITS(8)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   logic [7:0]         tbl_tag [SLOTS];
   logic [31:0]        tbl_period [SLOTS];
   logic signed [31:0] tbl_repeats [SLOTS];
   logic [31:0]        tbl_ticks [SLOTS];
   int                 tbl_active;
   logic               timer_running;

   rsp_type pending_rsp[$];
   int      error_count = 0;
   int      idle_cycles = 0;
   int      req_count = 0;
   int      rsp_count = 0;
   int      fired_count = 0;
   bit      long_hold = 1'b0;
   bit      hold_done = 1'b0;

   typedef struct {
      req_type    item;
      bit         has_check;
      status_type status;
   } vector_type;

   function automatic rsp_type mk_rsp(status_type st, int slot, logic [7:0] tag, bit last);
      rsp_type r;
      r.status = st;
      r.slot = slot[3:0];
      r.fired_tag = tag;
      r.last = last;
      return r;
   endfunction

   function automatic req_type mk_req(kind_type k, logic [7:0] tag, logic [31:0] per,
                                      logic signed [31:0] reps);
      req_type q;
      q.kind = k;
      q.callback_tag = tag;
      q.period_ticks = per;
      q.repeat_count = reps;
      return q;
   endfunction

   task automatic wipe_table();
      for (int i = 0; i < SLOTS; i++) begin
         tbl_tag[i] = '0;
         tbl_period[i] = '0;
         tbl_repeats[i] = '0;
         tbl_ticks[i] = '0;
      end
      tbl_active = 0;
   endtask

   task automatic release_slot(int i);
      tbl_tag[i] = '0;
      if (tbl_active > 0) tbl_active--;
   endtask

   task automatic predict_timer(req_type q);
      rsp_type fired[$];
      bit      placed;
      case (q.kind)
         KIND_REGISTER: begin
            placed = 1'b0;
            if (q.callback_tag != 0 && q.period_ticks != 0 && q.repeat_count != 0
                && tbl_active < SLOTS) begin
               for (int i = 0; i < SLOTS && !placed; i++) begin
                  if (tbl_tag[i] == 0) begin
                     tbl_tag[i] = q.callback_tag;
                     tbl_period[i] = q.period_ticks;
                     tbl_repeats[i] = q.repeat_count;
                     tbl_ticks[i] = '0;
                     tbl_active++;
                     pending_rsp.push_back(mk_rsp(ST_ACCEPTED, i, 8'd0, 1'b1));
                     placed = 1'b1;
                  end
               end
            end
            if (!placed) pending_rsp.push_back(mk_rsp(ST_REJECTED, 0, 8'd0, 1'b1));
         end
         KIND_UNREGISTER: begin
            placed = 1'b0;
            if (tbl_active != 0 && q.callback_tag != 0) begin
               for (int i = 0; i < SLOTS && !placed; i++) begin
                  if (tbl_tag[i] == q.callback_tag) begin
                     release_slot(i);
                     placed = 1'b1;
                  end
               end
            end
            pending_rsp.push_back(mk_rsp(ST_DONE, 0, 8'd0, 1'b1));
         end
         KIND_CLEAR_ALL: begin
            for (int i = 0; i < SLOTS; i++) tbl_tag[i] = '0;
            tbl_active = 0;
            timer_running = 1'b0;
            pending_rsp.push_back(mk_rsp(ST_DONE, 0, 8'd0, 1'b1));
         end
         KIND_TICK: begin
            if (!timer_running) begin
               pending_rsp.push_back(mk_rsp(ST_IGNORED, 0, 8'd0, 1'b1));
            end else if (tbl_active == 0) begin
               wipe_table();
               timer_running = 1'b0;
               pending_rsp.push_back(mk_rsp(ST_AUTOSTOP, 0, 8'd0, 1'b1));
            end else begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (tbl_tag[i] != 0) begin
                     tbl_ticks[i] = tbl_ticks[i] + 32'd1;
                     if (tbl_ticks[i] == tbl_period[i]) begin
                        tbl_ticks[i] = '0;
                        if (tbl_repeats[i] == 0) begin
                           release_slot(i);
                        end else begin
                           fired.push_back(mk_rsp(ST_FIRED, i, tbl_tag[i], 1'b0));
                           if (tbl_repeats[i] > 0) begin
                              tbl_repeats[i] = tbl_repeats[i] - 1;
                              if (tbl_repeats[i] == 0) release_slot(i);
                           end
                        end
                     end
                  end
               end
               if (fired.size() == 0) begin
                  pending_rsp.push_back(mk_rsp(ST_NONE, 0, 8'd0, 1'b1));
               end else begin
                  fired[fired.size()-1].last = 1'b1;
                  foreach (fired[k]) pending_rsp.push_back(fired[k]);
               end
            end
         end
         KIND_START: begin
            timer_running = 1'b1;
            pending_rsp.push_back(mk_rsp(ST_DONE, 0, 8'd0, 1'b1));
         end
         KIND_STOP: begin
            timer_running = 1'b0;
            pending_rsp.push_back(mk_rsp(ST_DONE, 0, 8'd0, 1'b1));
         end
         default: pending_rsp.push_back(mk_rsp(ST_REJECTED, 0, 8'd0, 1'b1));
      endcase
   endtask

   task automatic send_item(req_type q);
      req_data <= q;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      predict_timer(q);
      req_count++;
   endtask

   task automatic sender_gap();
      int n;
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) n = 0;
      if (n > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end else begin
         @(negedge clock);
      end
   endtask

   function automatic req_type random_item();
      logic [7:0]         tag;
      logic [31:0]        per;
      logic signed [31:0] reps;
      int                 pick;
      pick = $urandom_range(0, 99);
      tag = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 12));
      if ($urandom_range(0, 9) == 0) tag = 8'd0;
      per = ($urandom_range(0, 15) == 0) ? $urandom : 32'($urandom_range(1, 5));
      if ($urandom_range(0, 19) == 0) per = 32'd0;
      case ($urandom_range(0, 5))
         0: reps = -$signed(32'($urandom_range(1, 3)));
         1: reps = $signed($urandom);
         2: reps = 32'sd0;
         default: reps = $signed(32'($urandom_range(1, 4)));
      endcase
      if (pick < 25) return mk_req(KIND_REGISTER, tag, per, reps);
      if (pick < 33) return mk_req(KIND_UNREGISTER, tag, per, reps);
      if (pick < 35) return mk_req(KIND_CLEAR_ALL, tag, per, reps);
      if (pick < 85) return mk_req(KIND_TICK, tag, per, reps);
      if (pick < 93) return mk_req(KIND_START, tag, per, reps);
      if (pick < 96) return mk_req(KIND_STOP, tag, per, reps);
      return mk_req(kind_type'(3'($urandom_range(6, 7))), tag, per, reps);
   endfunction

   vector_type directed[$];

   initial begin
      req_type q;
      wipe_table();
      timer_running = 1'b0;
      directed = '{
         '{mk_req(KIND_TICK, 8'd0, 32'd0, 32'sd0), 1, ST_IGNORED},
         '{mk_req(KIND_REGISTER, 8'd0, 32'd1, 32'sd1), 1, ST_REJECTED},
         '{mk_req(KIND_REGISTER, 8'd5, 32'd0, 32'sd1), 1, ST_REJECTED},
         '{mk_req(KIND_REGISTER, 8'd5, 32'd1, 32'sd0), 1, ST_REJECTED},
         '{mk_req(KIND_UNREGISTER, 8'd5, 32'd0, 32'sd0), 1, ST_DONE},
         '{mk_req(KIND_START, 8'd0, 32'd0, 32'sd0), 1, ST_DONE},
         '{mk_req(KIND_TICK, 8'd0, 32'd0, 32'sd0), 1, ST_AUTOSTOP},
         '{mk_req(KIND_REGISTER, 8'hFF, 32'd1, 32'sh7FFFFFFF), 1, ST_ACCEPTED},
         '{mk_req(KIND_REGISTER, 8'h01, 32'hFFFFFFFF, 32'sh80000000), 0, ST_ACCEPTED},
         '{mk_req(KIND_REGISTER, 8'hAA, 32'd2, 32'sd1), 0, ST_ACCEPTED},
         '{mk_req(KIND_REGISTER, 8'h55, 32'd1, -32'sd1), 0, ST_ACCEPTED},
         '{mk_req(KIND_START, 8'd0, 32'd0, 32'sd0), 1, ST_DONE},
         '{mk_req(KIND_TICK, 8'd0, 32'd0, 32'sd0), 0, ST_FIRED},
         '{mk_req(KIND_TICK, 8'd0, 32'd0, 32'sd0), 0, ST_FIRED},
         '{mk_req(KIND_UNREGISTER, 8'd0, 32'd0, 32'sd0), 1, ST_DONE},
         '{mk_req(KIND_UNREGISTER, 8'h99, 32'd0, 32'sd0), 1, ST_DONE},
         '{mk_req(KIND_UNREGISTER, 8'h55, 32'd0, 32'sd0), 1, ST_DONE},
         '{mk_req(kind_type'(3'd6), 8'd0, 32'd0, 32'sd0), 1, ST_REJECTED},
         '{mk_req(kind_type'(3'd7), 8'hFF, 32'hFFFFFFFF, -32'sd1), 1, ST_REJECTED},
         '{mk_req(KIND_STOP, 8'd0, 32'd0, 32'sd0), 1, ST_DONE},
         '{mk_req(KIND_TICK, 8'd0, 32'd0, 32'sd0), 1, ST_IGNORED},
         '{mk_req(KIND_CLEAR_ALL, 8'd0, 32'd0, 32'sd0), 1, ST_DONE}
      };
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed[d]) begin
         send_item(directed[d].item);
         if (directed[d].has_check && pending_rsp[$].status != directed[d].status) begin
            $error("directed row %0d: status expected %0d, predicted %0d", d,
                   directed[d].status, pending_rsp[$].status);
            error_count++;
         end
         sender_gap();
      end
      // fill the table so full-table rejects occur
      for (int i = 0; i < SLOTS + 1; i++) begin
         send_item(mk_req(KIND_REGISTER, 8'(i + 1), 32'd3, -32'sd1));
         @(negedge clock);
      end
      send_item(mk_req(KIND_START, 8'd0, 32'd0, 32'sd0));
      @(negedge clock);
      long_hold = 1'b1;
      for (int i = 0; i < 12; i++) begin
         send_item(mk_req(KIND_TICK, 8'd0, 32'd0, 32'sd0));
         @(negedge clock);
      end
      long_hold = 1'b0;
      req_valid <= 1'b0;
      wait (pending_rsp.size() == 0);
      @(negedge clock);
      for (int i = 0; i < 290; i++) begin
         q = random_item();
         if (q.kind == KIND_CLEAR_ALL && $urandom_range(0, 1) == 0) q.kind = KIND_TICK;
         send_item(q);
         sender_gap();
         if (i == 150) begin
            req_valid <= 1'b0;
            wait (pending_rsp.size() == 0);
            @(negedge clock);
         end
      end
      req_valid <= 1'b0;
      wait (pending_rsp.size() == 0);
      repeat (SLOTS * 4 + 20) @(posedge clock);
      $display("Covered %0d requests and %0d responses (%0d timer firings),",
               req_count, rsp_count, fired_count);
      $display("including full-table rejects, wrap-limit periods and output backpressure.");
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // receiver backpressure
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (long_hold && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (150) @(negedge clock);
            hold_done = 1'b1;
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 3) == 0) begin
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_count++;
         if (pending_rsp.size() == 0) begin
            $error("response with no expectation: %p", rsp_data);
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.status == ST_FIRED) fired_count++;
            if (rsp_data.status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.slot !== want.slot) begin
               $error("slot expected %0d actual %0d", want.slot, rsp_data.slot);
               error_count++;
            end
            if (rsp_data.fired_tag !== want.fired_tag) begin
               $error("fired_tag expected %0h actual %0h", want.fired_tag, rsp_data.fired_tag);
               error_count++;
            end
            if (rsp_data.last !== want.last) begin
               $error("last expected %0b actual %0b", want.last, rsp_data.last);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

endmodule
